FILE: hw/rtl/double_ended_priority_queue_macros.svh
// assertion macros for the double-ended priority queue
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DPQ_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define DPQ_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define DPQ_ASSERT_IMP(lbl, pre, post, msg)
`define DPQ_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

FILE: hw/rtl/dpq_pkg.sv
`timescale 1ns / 1ps

package dpq_pkg;

  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 9;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE_MAX = 2'd2,
    OP_CLEAR      = 2'd3
  } dpq_op_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rmin;
    logic                    rmax;
    logic                    clr;
    logic signed [VAL_W-1:0] value;
  } dpq_cmd_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic                    valid;
    logic                    a_gt;
    logic                    d_lt;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] d;
  } dpq_link_t;

  localparam dpq_link_t LINK_LO = '{
    valid: 1'b1,
    a_gt:  1'b0,
    d_lt:  1'b0,
    a:     {1'b1, {(VAL_W-1){1'b0}}},
    d:     {1'b0, {(VAL_W-1){1'b1}}}
  };

  localparam dpq_link_t LINK_HI = '{
    valid: 1'b0,
    a_gt:  1'b0,
    d_lt:  1'b0,
    a:     '0,
    d:     '0
  };

endpackage

FILE: hw/rtl/dpq_cell.sv
`timescale 1ns / 1ps
`include "double_ended_priority_queue_macros.svh"

module dpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dpq_pkg::dpq_cmd_t  cmd,
  input  dpq_pkg::dpq_link_t left,
  input  dpq_pkg::dpq_link_t right,
  output dpq_pkg::dpq_link_t link_o
);
  import dpq_pkg::*;

  // a: ascending row, d: descending row
  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;
  logic signed [VAL_W-1:0] d_r, d_nxt;
  logic                    a_gt, d_lt;

  assign a_gt = valid_r && (a_r > cmd.value);
  assign d_lt = valid_r && (d_r < cmd.value);

  always_comb begin
    valid_nxt = valid_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins) begin
      valid_nxt = left.valid;
      if (left.a_gt) begin
        a_nxt = left.a;
      end else if (a_gt || !valid_r) begin
        a_nxt = cmd.value;
      end
      if (left.d_lt) begin
        d_nxt = left.d;
      end else if (d_lt || !valid_r) begin
        d_nxt = cmd.value;
      end
    end else if (cmd.rmin) begin
      valid_nxt = right.valid;
      a_nxt     = right.a;
    end else if (cmd.rmax) begin
      valid_nxt = right.valid;
      d_nxt     = right.d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    d_r <= d_nxt;
  end

  assign link_o = '{valid: valid_r, a_gt: a_gt, d_lt: d_lt, a: a_r, d: d_r};

  `DPQ_ASSERT_IMP(a_fill_contiguous, valid_r, left.valid, "occupied cell after an empty one")
  `DPQ_ASSERT_IMP(a_asc_order, valid_r, left.a <= a_r, "ascending row out of order")
  `DPQ_ASSERT_IMP(a_desc_order, valid_r, left.d >= d_r, "descending row out of order")

endmodule

FILE: hw/rtl/double_ended_priority_queue.sv
// an accepted request updates the cells and sets pend_r; the result is registered once the output register is free
// throughput: one request per cycle, every cell of the chain updates in that cycle
// a new request waits only while the previous result is held by out_ready low
// the chain holds two sorted rows so both ends sit in the first cell
// reset: synchronous active-low rst_n empties the queue and drops pending results
`timescale 1ns / 1ps
`include "double_ended_priority_queue_macros.svh"

module double_ended_priority_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  dpq_pkg::dpq_op_t                   in_operation,
  input  logic signed [dpq_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_is_empty,
  output logic signed [dpq_pkg::VAL_W-1:0]   out_max_value,
  output logic signed [dpq_pkg::VAL_W-1:0]   out_min_value,
  output logic                               out_overflow,
  output logic [dpq_pkg::OCC_W-1:0]          out_occupancy
);
  import dpq_pkg::*;

  logic             accept;
  logic             full;
  logic             nonzero;
  dpq_cmd_t         cmd;
  dpq_link_t        links [CAPACITY];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r, pend_nxt;
  logic             ovf_r, ovf_nxt;
  logic             move;
  logic             out_valid_r;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign nonzero = (count_r != '0);
  assign move    = pend_r && (!out_valid_r || out_ready);
  assign in_ready = !pend_r || move;
  assign accept  = in_valid && in_ready;

  always_comb begin
    cmd       = '{ins: 1'b0, rmin: 1'b0, rmax: 1'b0, clr: 1'b0, value: in_value};
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      ovf_nxt = 1'b0;
      unique case (in_operation)
        OP_INSERT: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE_MIN: begin
          cmd.rmin = 1'b1;
          if (nonzero) begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_REMOVE_MAX: begin
          cmd.rmax = 1'b1;
          if (nonzero) begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_CLEAR: begin
          cmd.clr   = 1'b1;
          count_nxt = '0;
        end
        default: begin
          cmd.clr = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dpq_link_t left_s, right_s;
    if (i == 0) begin : g_lo
      assign left_s = LINK_LO;
    end else begin : g_mid_lo
      assign left_s = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_s = LINK_HI;
    end else begin : g_mid_hi
      assign right_s = links[i+1];
    end
    dpq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .left   (left_s),
      .right  (right_s),
      .link_o (links[i])
    );
  end

  assign pend_nxt = accept || (pend_r && !move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    if (move) begin
      out_is_empty  <= !links[0].valid;
      out_max_value <= links[0].valid ? links[0].d : '0;
      out_min_value <= links[0].valid ? links[0].a : '0;
      out_overflow  <= ovf_r;
      out_occupancy <= OCC_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;

  `DPQ_ASSERT_IMP(a_count_matches, 1'b1, nonzero == links[0].valid, "count and cells disagree")
  `DPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `DPQ_ASSERT_IMP(a_ends_ordered, links[0].valid, links[0].a <= links[0].d,
                  "minimum above maximum")
  `DPQ_ASSERT_NXT(a_full_drop, accept && full && in_operation == OP_INSERT,
                  ovf_r && full, "dropped insert not flagged")

endmodule
